// ===== sv/fmr_pkg.sv =====
// Shared types, constants and helpers for the float mid-range stream block.
// No dependencies; imported by the top level and the sum unit.
`timescale 1ns / 1ps
`default_nettype none
package fmr_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned SumW = 28;

	localparam logic [31:0] NegZero = 32'h8000_0000;
	localparam logic [31:0] QNan = 32'h7FC0_0000;
	localparam logic [7:0] ExpMax = 8'hFF;

	typedef enum logic [1:0] {
		CNT_NONE = 2'd0,
		CNT_ONE  = 2'd1,
		CNT_MANY = 2'd2
	} fmr_cnt_t;

	// Request handed to the sum unit on the last word of a set.
	typedef struct packed {
		logic        pass;
		logic [31:0] pass_bits;
		logic [31:0] mx;
		logic [31:0] mn;
	} fmr_req_t;

	function automatic logic is_nan(input logic [31:0] b);
		return (b[30:23] == ExpMax) && (b[22:0] != 23'd0);
	endfunction

	// Map float bits onto an unsigned key that orders -0 below +0.
	function automatic logic [31:0] order_key(input logic [31:0] b);
		return b[31] ? ~b : {1'b1, b[30:0]};
	endfunction

endpackage
`default_nettype wire

// ===== sv/float_midrange_stream_top.sv =====
// Top level of the float mid-range stream block: input stage, running min/max
// and the sum unit. Depends on fmr_pkg and fmr_sum_unit.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------
//  s_      | in  | s_tvalid/s_tready| s_tdata = sample[31:0], s_tlast = is_last
//  m_      | out | m_tvalid/m_tready| m_tdata = midrange[31:0]
//
// One word per cycle enters unless the output is stalled; no gaps are required.
// After the last word is accepted, the accepting edge loads the input stage,
// then the min/max update loads the request register, the add loads the sum
// register, and normalize/round/halve loads the output register and m_tvalid.
// Reset clears all valid bits and the running set state at once.
// A stalled output word freezes the whole pipeline; s_tready drops only then.
`timescale 1ns / 1ps
`default_nettype none
module float_midrange_stream_top
	import fmr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [WordW-1:0]  s_tdata,   // [31:0] sample
	input  wire logic              s_tlast,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [WordW-1:0]       m_tdata    // [31:0] midrange
);

	logic adv;

	// advance every stage unless the output word is held
	assign adv = ~(m_tvalid & ~m_tready);
	assign s_tready = adv;

	// input stage
	logic        vld_s1;
	logic [31:0] sample_s1;
	logic        last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// running set state
	logic [31:0] run_min_q, run_max_q, nan_bits_q;
	fmr_cnt_t    cnt_q;
	logic        nan_q;

	logic [31:0] min_n, max_n, nan_bits_n;
	fmr_cnt_t    cnt_n;
	logic        nan_n;
	fmr_req_t    req;

	always_comb begin
		min_n = run_min_q;
		max_n = run_max_q;
		nan_bits_n = nan_bits_q;
		cnt_n = cnt_q;
		nan_n = nan_q;
		if (!nan_q) begin
			if (is_nan(sample_s1)) begin
				nan_n = 1'b1;
				nan_bits_n = sample_s1;
			end else if (cnt_q == CNT_NONE) begin
				min_n = sample_s1;
				max_n = sample_s1;
				cnt_n = CNT_ONE;
			end else begin
				// key order puts -0 below +0, matching the signed-zero preference
				if (order_key(sample_s1) < order_key(run_min_q)) begin
					min_n = sample_s1;
				end else if (order_key(sample_s1) > order_key(run_max_q)) begin
					max_n = sample_s1;
				end
				cnt_n = CNT_MANY;
			end
		end
		req.pass = nan_n | (cnt_n != CNT_MANY);
		req.pass_bits = nan_n ? nan_bits_n : min_n;
		req.mx = max_n;
		req.mn = min_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= '0;
			run_max_q <= '0;
			nan_bits_q <= '0;
			cnt_q <= CNT_NONE;
			nan_q <= 1'b0;
		end else if (adv && vld_s1) begin
			if (last_s1) begin
				// drop the set state once its result is on its way
				run_min_q <= '0;
				run_max_q <= '0;
				nan_bits_q <= '0;
				cnt_q <= CNT_NONE;
				nan_q <= 1'b0;
			end else begin
				run_min_q <= min_n;
				run_max_q <= max_n;
				nan_bits_q <= nan_bits_n;
				cnt_q <= cnt_n;
				nan_q <= nan_n;
			end
		end
	end

	// request register toward the sum unit
	logic     vld_s2;
	fmr_req_t req_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1 & last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s2 <= req;
		end
	end

	fmr_sum_unit u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.req_vld  (vld_s2),
		.req      (req_s2),
		.res_vld  (m_tvalid),
		.res_bits (m_tdata)
	);

endmodule
`default_nettype wire

// ===== sv/fmr_sum_unit.sv =====
// Sum unit: align and add max+min, then normalize, round and halve; special values pass unhalved.
// Depends on fmr_pkg. Two register stages: sum register and result register.
`timescale 1ns / 1ps
`default_nettype none
module fmr_sum_unit
	import fmr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        req_vld,
	input  wire fmr_req_t    req,
	output logic             res_vld,
	output logic [31:0]      res_bits
);

	logic            vld_s3;
	logic            spec_s3;
	logic [31:0]     spec_bits_s3;
	logic            sign_s3;
	logic            sub_s3;
	logic [8:0]      exp_s3;
	logic [SumW-1:0] sum_s3;

	// align and add
	logic            a_inf, b_inf, spec;
	logic [31:0]     spec_bits, big, lit;
	logic [7:0]      ea, eb, d;
	logic [23:0]     ma, mb;
	logic [26:0]     av, bfull, bs, mask;
	logic            sticky, sub;
	logic [SumW-1:0] sum;

	always_comb begin
		a_inf = req.mx[30:23] == ExpMax;
		b_inf = req.mn[30:23] == ExpMax;
		spec = 1'b1;
		spec_bits = req.pass_bits;
		if (req.pass) begin
			spec_bits = req.pass_bits;
		end else if (a_inf && b_inf && (req.mx[31] != req.mn[31])) begin
			spec_bits = QNan;
		end else if (a_inf) begin
			spec_bits = req.mx;
		end else if (b_inf) begin
			spec_bits = req.mn;
		end else begin
			spec = 1'b0;
		end
		if (req.mx[30:0] >= req.mn[30:0]) begin
			big = req.mx;
			lit = req.mn;
		end else begin
			big = req.mn;
			lit = req.mx;
		end
		ea = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		eb = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
		ma = {big[30:23] != 8'd0, big[22:0]};
		mb = {lit[30:23] != 8'd0, lit[22:0]};
		d = ea - eb;
		av = {ma, 3'b000};
		bfull = {mb, 3'b000};
		mask = 27'd0;
		if (d >= 8'd27) begin
			bs = 27'd0;
			sticky = |mb;
		end else begin
			mask = ~(27'h7FF_FFFF << d[4:0]);
			bs = bfull >> d[4:0];
			sticky = |(bfull & mask);
		end
		bs[0] = bs[0] | sticky;
		sub = big[31] != lit[31];
		sum = sub ? ({1'b0, av} - {1'b0, bs}) : ({1'b0, av} + {1'b0, bs});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= req_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s3 <= spec;
			spec_bits_s3 <= spec_bits;
			sign_s3 <= big[31];
			sub_s3 <= sub;
			exp_s3 <= {1'b0, ea};
			sum_s3 <= sum;
		end
	end

	// normalize, round, halve
	logic [26:0] n;
	logic [8:0]  e, lz, sh;
	logic        up;
	logic [24:0] m25;
	logic [23:0] m, hm, h;
	logic [7:0]  field;
	logic [31:0] s, half;

	always_comb begin
		lz = 9'd27;
		for (int i = 0; i < 27; i++) begin
			if (sum_s3[i]) begin
				lz = 9'(26 - i);
			end
		end
		if (sum_s3[27]) begin
			n = sum_s3[27:1];
			n[0] = sum_s3[1] | sum_s3[0];
			e = exp_s3 + 9'd1;
			sh = 9'd0;
		end else begin
			sh = (lz < exp_s3 - 9'd1) ? lz : exp_s3 - 9'd1;
			n = sum_s3[26:0] << sh[4:0];
			e = exp_s3 - sh;
		end
		up = n[2] & (n[3] | n[1] | n[0]);
		m25 = {1'b0, n[26:3]} + 25'(up);
		if (m25[24]) begin
			m = m25[24:1];
			e = e + 9'd1;
		end else begin
			m = m25[23:0];
		end
		field = m[23] ? e[7:0] : 8'd0;
		if (sum_s3 == '0) begin
			s = {sign_s3 & ~sub_s3, 31'd0};
		end else if (e >= 9'd255) begin
			s = {sign_s3, ExpMax, 23'd0};
		end else begin
			s = {sign_s3, field, m[22:0]};
		end
		if (spec_s3) begin
			s = spec_bits_s3;
		end
		// halve: exact exponent step for normals, rounded shift near subnormal range
		hm = {s[30:23] == 8'd1, s[22:0]};
		h = (hm >> 1) + 24'(hm[0] & hm[1]);
		if (spec_s3 || s[30:23] >= 8'd2) begin
			half = (spec_s3 || s[30:23] == ExpMax) ? s : {s[31], s[30:23] - 8'd1, s[22:0]};
		end else begin
			half = {s[31], 7'd0, h};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld <= 1'b0;
		end else if (en) begin
			res_vld <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_bits <= half;
		end
	end

endmodule
`default_nettype wire

// ===== sv/fmr_checker.sv =====
// Port-level checker for float_midrange_stream_top, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module fmr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == !(m_tvalid && !m_tready))
		else $error("input ready does not follow output stall");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) ##1 s_tready ##1 s_tready ##1 s_tready
		|=> m_tvalid)
		else $error("result missing after last word");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind float_midrange_stream_top fmr_checker u_fmr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
